[rtl/core/shg_pkg.sv]
// Package with shared types and codes of the spatial hash grid core.
`timescale 1ns / 1ps
package shg_pkg;
  localparam logic [1:0] CMD_CLEAR    = 2'd0;
  localparam logic [1:0] CMD_INSERT   = 2'd1;
  localparam logic [1:0] CMD_QUERY    = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam logic [1:0] ST_ENTRY = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_NONE  = 2'd3;

  localparam logic [1:0] REG_CELL_SIZE = 2'd0;
  localparam logic [1:0] REG_PRIME_X   = 2'd1;
  localparam logic [1:0] REG_PRIME_Y   = 2'd2;

  // One command handed from the front to the back: a command, its particle id and its nine bucket hashes.
  typedef struct packed {
    logic [1:0]       command;
    logic [15:0]      particle_id;
    logic [8:0][31:0] hashes;
  } cmd_t;
endpackage

[rtl/core/spatial_hash_grid_neighbours_core.sv]
// Top level of the spatial hash grid core with its register file.
`timescale 1ns / 1ps
// Spatial hash grid for neighbour search. Every command passes through the
// front end (a restoring divider for the cell index, nine hashes on one
// shared pair of multipliers with registered products, a hand-off state and
// an idle state to take the next transaction). The back end answers an insert
// once its bucket count is read and an unknown command when it takes it; a
// query walks its nine buckets, reading each bucket count and then each found
// id through the single read port of the entry memory, up to 63 ids in all.
// After reset, and after each clear command, a sweep over all TABLE_SIZE
// buckets empties the bucket counts; no item enters the back end meanwhile,
// while register writes are taken at any time. The front end works on the next
// item while the back end is busy.
module spatial_hash_grid_neighbours_core #(
  parameter int TABLE_SIZE      = 1024,
  parameter int BUCKET_CAPACITY = 7,
  parameter int COORD_BITS      = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,  // command[1:0], particle_id[17:2], pos_x[33:18], pos_y[49:34]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // neighbour_id[15:0], status[17:16]
  output logic        m_axis_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [15:0] cell_size_q;
  logic [31:0] prime_x_q, prime_y_q;
  logic          fcv, fcr, bcv, bcr;
  shg_pkg::cmd_t fc, bc;
  logic [15:0]   nid;
  logic [1:0]    st;

  assign pready = 1'b1;

  // Register writes and reads.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= 16'd16; prime_x_q <= 32'd73856093; prime_y_q <= 32'd19349663;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        shg_pkg::REG_CELL_SIZE: cell_size_q <= pwdata[15:0];
        shg_pkg::REG_PRIME_X:   prime_x_q <= pwdata;
        shg_pkg::REG_PRIME_Y:   prime_y_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      shg_pkg::REG_CELL_SIZE: prdata = {16'd0, cell_size_q};
      shg_pkg::REG_PRIME_X:   prdata = prime_x_q;
      shg_pkg::REG_PRIME_Y:   prdata = prime_y_q;
      default:                prdata = 32'd0;
    endcase
  end

  shg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .command_i(s_axis_tdata_i[1:0]), .particle_id_i(s_axis_tdata_i[17:2]),
    .pos_x_i(s_axis_tdata_i[33:18]), .pos_y_i(s_axis_tdata_i[49:34]),
    .cell_size_i(cell_size_q), .prime_x_i(prime_x_q), .prime_y_i(prime_y_q),
    .cmd_valid_o(fcv), .cmd_ready_i(fcr), .cmd_o(fc)
  );

  shg_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(fcv), .wr_ready_o(fcr), .wr_data_i(fc),
    .rd_valid_o(bcv), .rd_ready_i(bcr), .rd_data_o(bc)
  );

  shg_back #(.TABLE_SIZE(TABLE_SIZE), .BUCKET_CAPACITY(BUCKET_CAPACITY)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(bcv), .cmd_ready_o(bcr), .cmd_i(bc),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .neighbour_id_o(nid), .status_o(st), .last_o(m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {6'd0, st, nid};
endmodule

[rtl/core/shg_front.sv]
// Front end: divides positions by the cell size and hashes the 3x3 cells.
`timescale 1ns / 1ps
module shg_front #(
  parameter int COORD_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       command_i,
  input  logic [15:0]      particle_id_i,
  input  logic [15:0]      pos_x_i,
  input  logic [15:0]      pos_y_i,
  input  logic [15:0]      cell_size_i,
  input  logic [31:0]      prime_x_i,
  input  logic [31:0]      prime_y_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output shg_pkg::cmd_t    cmd_o
);
  localparam int CB = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int PH_IDLE = 0, PH_DIV = 1, PH_HASH = 2, PH_OUT = 3;

  logic [1:0]  phase_q, phase_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] qx_q, qx_d, qy_q, qy_d;
  logic [16:0] rx_q, rx_d, ry_q, ry_d;
  logic [15:0] div_q, div_d;
  logic [31:0] mx_q, mx_d, my_q, my_d;
  shg_pkg::cmd_t cmd_q, cmd_d;
  logic [16:0] rxs, rys;
  logic [31:0] cxs, cys, px, py;
  logic [1:0]  dx, dy;

  assign in_ready_o  = (phase_q == 2'(PH_IDLE));
  assign cmd_valid_o = (phase_q == 2'(PH_OUT));
  assign cmd_o       = cmd_q;

  // One hash per cycle: cnt walks dx outer, dy inner.
  always_comb begin
    case (cnt_q)
      5'd3, 5'd4, 5'd5: dx = 2'd1;
      5'd6, 5'd7, 5'd8: dx = 2'd2;
      default: dx = 2'd0;
    endcase
    case (cnt_q)
      5'd1, 5'd4, 5'd7: dy = 2'd1;
      5'd2, 5'd5, 5'd8: dy = 2'd2;
      default: dy = 2'd0;
    endcase
    cxs = 32'(qx_q) + 32'(dx) - 32'd1;
    cys = 32'(qy_q) + 32'(dy) - 32'd1;
    px  = cxs * prime_x_i;
    py  = cys * prime_y_i;
  end

  // Restoring division of both coordinates, one quotient bit per cycle.
  always_comb begin
    rxs = {rx_q[15:0], qx_q[15]};
    rys = {ry_q[15:0], qy_q[15]};
  end

  always_comb begin
    phase_d = phase_q; cnt_d = cnt_q; qx_d = qx_q; qy_d = qy_q;
    rx_d = rx_q; ry_d = ry_q; div_d = div_q; mx_d = mx_q; my_d = my_q; cmd_d = cmd_q;
    case (phase_q)
      2'(PH_IDLE): begin
        if (in_valid_i) begin
          cmd_d.command     = command_i;
          cmd_d.particle_id = particle_id_i;
          qx_d  = 16'(pos_x_i[CB-1:0]);
          qy_d  = 16'(pos_y_i[CB-1:0]);
          rx_d  = '0; ry_d = '0;
          div_d = (cell_size_i == 16'd0) ? 16'd1 : cell_size_i;
          cnt_d = '0;
          phase_d = 2'(PH_DIV);
        end
      end
      2'(PH_DIV): begin
        if (rxs >= {1'b0, div_q}) begin
          rx_d = rxs - {1'b0, div_q}; qx_d = {qx_q[14:0], 1'b1};
        end else begin
          rx_d = rxs; qx_d = {qx_q[14:0], 1'b0};
        end
        if (rys >= {1'b0, div_q}) begin
          ry_d = rys - {1'b0, div_q}; qy_d = {qy_q[14:0], 1'b1};
        end else begin
          ry_d = rys; qy_d = {qy_q[14:0], 1'b0};
        end
        if (cnt_q == 5'd15) begin
          cnt_d = '0; phase_d = 2'(PH_HASH);
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      2'(PH_HASH): begin
        // Products are registered; the xor of each pair lands in the next cycle.
        mx_d = px; my_d = py;
        if (cnt_q != 5'd0) cmd_d.hashes[4'(cnt_q - 5'd1)] = mx_q ^ my_q;
        if (cnt_q == 5'd9) begin
          phase_d = 2'(PH_OUT);
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      2'(PH_OUT): begin
        if (cmd_ready_i) phase_d = 2'(PH_IDLE);
      end
      default: phase_d = 2'(PH_IDLE);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'(PH_IDLE);
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qx_q <= qx_d; qy_q <= qy_d; rx_q <= rx_d; ry_q <= ry_d;
    div_q <= div_d; mx_q <= mx_d; my_q <= my_d; cmd_q <= cmd_d;
  end
endmodule

[rtl/core/shg_fifo.sv]
// Two-entry queue between the front and back ends.
`timescale 1ns / 1ps
module shg_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  shg_pkg::cmd_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output shg_pkg::cmd_t rd_data_o
);
  shg_pkg::cmd_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

[rtl/core/shg_back.sv]
// Back end: bucket storage, clear, insert and the query walk with an output register.
`timescale 1ns / 1ps
module shg_back #(
  parameter int TABLE_SIZE      = 1024,
  parameter int BUCKET_CAPACITY = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  shg_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [15:0]   neighbour_id_o,
  output logic [1:0]    status_o,
  output logic          last_o
);
  localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int EW = $clog2(TABLE_SIZE * BUCKET_CAPACITY);
  localparam int S_INIT = 0, S_IDLE = 1, S_CNT = 2, S_CWAIT = 3, S_ENT = 4,
                 S_EWAIT = 5, S_EMIT = 6;

  // Bucket counts cleared by a sweep; entries need no reset.
  logic [2:0]  count_mem [TABLE_SIZE];
  logic [15:0] entry_mem [TABLE_SIZE * BUCKET_CAPACITY];

  logic [2:0]    st_q, st_d;
  logic [AW-1:0] sweep_q, sweep_d;
  logic [3:0]    cell_q, cell_d;
  logic [2:0]    ent_q, ent_d, ccnt_q, ccnt_d;
  logic          found_q, found_d;
  logic [15:0]   pend_q, pend_d;
  logic [AW-1:0] bkt_q, bkt_d;
  shg_pkg::cmd_t cmd_q, cmd_d;

  logic          cnt_we, ent_we, ent_re, cnt_re;
  logic [AW-1:0] cnt_wa, cnt_ra;
  logic [2:0]    cnt_wd, cnt_rd_q;
  logic [EW-1:0] ent_wa, ent_ra;
  logic [15:0]   ent_rd_q;

  logic        ov_q, ov_d, last_q, last_d;
  logic [15:0] oid_q, oid_d;
  logic [1:0]  ost_q, ost_d;
  logic        obusy;
  logic [AW-1:0] hsel;

  assign out_valid_o    = ov_q;
  assign neighbour_id_o = oid_q;
  assign status_o       = ost_q;
  assign last_o         = last_q;
  assign obusy          = ov_q && !out_ready_i;
  assign cmd_ready_o    = (st_q == 3'(S_IDLE)) && !obusy;
  assign hsel = AW'(cmd_q.hashes[cell_q] % 32'(TABLE_SIZE));

  always_comb begin
    st_d = st_q; sweep_d = sweep_q; cell_d = cell_q; ent_d = ent_q; ccnt_d = ccnt_q;
    found_d = found_q; pend_d = pend_q; bkt_d = bkt_q; cmd_d = cmd_q;
    cnt_we = 1'b0; cnt_wa = sweep_q; cnt_wd = '0; cnt_re = 1'b0; cnt_ra = hsel;
    ent_we = 1'b0; ent_re = 1'b0;
    ent_wa = EW'(bkt_q * BUCKET_CAPACITY + 32'(ccnt_q));
    ent_ra = EW'(bkt_q * BUCKET_CAPACITY + 32'(ent_q));
    ov_d = ov_q && !out_ready_i; oid_d = oid_q; ost_d = ost_q; last_d = last_q;
    case (st_q)
      3'(S_INIT): begin
        cnt_we = 1'b1;
        sweep_d = sweep_q + AW'(1);
        if (32'(sweep_q) == TABLE_SIZE - 1) st_d = 3'(S_IDLE);
      end
      3'(S_IDLE): begin
        if (cmd_valid_i && !obusy) begin
          // An insert uses the center cell, which is hash 4 of the 3x3 walk.
          cmd_d = cmd_i; found_d = 1'b0;
          cell_d = (cmd_i.command == shg_pkg::CMD_INSERT) ? 4'd4 : 4'd0;
          case (cmd_i.command)
            shg_pkg::CMD_CLEAR: begin
              sweep_d = '0; st_d = 3'(S_INIT);
              ov_d = 1'b1; oid_d = '0; ost_d = shg_pkg::ST_DONE; last_d = 1'b1;
            end
            shg_pkg::CMD_INSERT, shg_pkg::CMD_QUERY: st_d = 3'(S_CNT);
            default: begin
              ov_d = 1'b1; oid_d = '0; ost_d = shg_pkg::ST_DONE; last_d = 1'b1;
            end
          endcase
        end
      end
      3'(S_CNT): begin
        cnt_re = 1'b1; bkt_d = hsel; st_d = 3'(S_CWAIT);
      end
      3'(S_CWAIT): begin
        ccnt_d = (cnt_rd_q > 3'(BUCKET_CAPACITY)) ? 3'(BUCKET_CAPACITY) : cnt_rd_q;
        ent_d = '0;
        if (cmd_q.command == shg_pkg::CMD_INSERT) begin
          if (!obusy) begin
            ov_d = 1'b1; oid_d = '0; last_d = 1'b1; st_d = 3'(S_IDLE);
            if (cnt_rd_q >= 3'(BUCKET_CAPACITY)) begin
              ost_d = shg_pkg::ST_FULL;
            end else begin
              ost_d = shg_pkg::ST_DONE;
              ccnt_d = cnt_rd_q;
              ent_we = 1'b1;
              ent_wa = EW'(bkt_q * BUCKET_CAPACITY + 32'(cnt_rd_q));
              cnt_we = 1'b1; cnt_wa = bkt_q; cnt_wd = cnt_rd_q + 3'd1;
            end
          end else begin
            st_d = 3'(S_CWAIT);
          end
        end else begin
          st_d = 3'(S_ENT);
        end
      end
      3'(S_ENT): begin
        if (ent_q < ccnt_q) begin
          ent_re = 1'b1; st_d = 3'(S_EWAIT);
        end else if (cell_q == 4'd8) begin
          st_d = 3'(S_EMIT);
        end else begin
          cell_d = cell_q + 4'd1; st_d = 3'(S_CNT);
        end
      end
      3'(S_EWAIT): begin
        // The newest found id waits in pend_q and the one before it goes out, as only
        // the end of the walk tells which id carries the last mark.
        if (!obusy) begin
          if (found_q) begin
            ov_d = 1'b1; last_d = 1'b0;
            oid_d = pend_q; ost_d = shg_pkg::ST_ENTRY;
          end
          pend_d = ent_rd_q;
          found_d = 1'b1; ent_d = ent_q + 3'd1; st_d = 3'(S_ENT);
        end
      end
      3'(S_EMIT): begin
        if (!obusy) begin
          ov_d = 1'b1; last_d = 1'b1; st_d = 3'(S_IDLE);
          if (found_q) begin
            oid_d = pend_q; ost_d = shg_pkg::ST_ENTRY;
          end else begin
            oid_d = '0; ost_d = shg_pkg::ST_NONE;
          end
        end
      end
      default: st_d = 3'(S_IDLE);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= 3'(S_INIT); sweep_q <= '0; ov_q <= 1'b0; found_q <= 1'b0;
    end else begin
      st_q <= st_d; sweep_q <= sweep_d; ov_q <= ov_d; found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d; ent_q <= ent_d; ccnt_q <= ccnt_d; bkt_q <= bkt_d; cmd_q <= cmd_d;
    oid_q <= oid_d; ost_q <= ost_d; last_q <= last_d; pend_q <= pend_d;
  end

  // Count memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cnt_we) count_mem[cnt_wa] <= cnt_wd;
    if (cnt_re) cnt_rd_q <= count_mem[cnt_ra];
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ent_we) entry_mem[ent_wa] <= cmd_q.particle_id;
    if (ent_re) ent_rd_q <= entry_mem[ent_ra];
  end
endmodule

[sim/spatial_hash_grid_neighbours_checker.sv]
// Checker that predicts and compares the result stream of the spatial hash grid core.
`timescale 1ns / 1ps
module spatial_hash_grid_neighbours_checker #(
  parameter int TABLE_SIZE      = 1024,
  parameter int BUCKET_CAPACITY = 7,
  parameter int COORD_BITS      = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [55:0] s_axis_tdata_i,  // command, particle_id, pos_x, pos_y
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [23:0] m_axis_tdata_i,  // neighbour_id, status
  input  logic        m_axis_tlast_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          mismatch_count_o,
  output int          pending_count_o
);

  typedef struct {
    logic [15:0] id;
    logic [1:0]  status;
    logic        last;
  } grid_result_t;

  // Shadow copy of the grid and of the registers.
  logic [15:0]  cell_size_q;
  logic [31:0]  prime_x_q;
  logic [31:0]  prime_y_q;
  int           fill_q [TABLE_SIZE];
  logic [15:0]  ids_q  [TABLE_SIZE][BUCKET_CAPACITY];
  grid_result_t want_q [$];

  function automatic logic [31:0] cell_of(logic [15:0] pos);
    logic [31:0] edge_len;
    logic [31:0] p;
    edge_len = (cell_size_q == 16'd0) ? 32'd1 : 32'(cell_size_q);
    p        = 32'(pos) & ((32'd1 << COORD_BITS) - 32'd1);
    return p / edge_len;
  endfunction

  function automatic int bucket_of(logic [31:0] cx, logic [31:0] cy);
    logic [31:0] h;
    h = (cx * prime_x_q) ^ (cy * prime_y_q);
    return int'(h % TABLE_SIZE);
  endfunction

  // Work out the results of one accepted command and queue them.
  task automatic predict_grid(logic [55:0] word);
    logic [1:0]   cmd;
    logic [15:0]  pid;
    logic [31:0]  cx;
    logic [31:0]  cy;
    int           b;
    int           found;
    grid_result_t r;
    cmd   = word[1:0];
    pid   = word[17:2];
    cx    = cell_of(word[33:18]);
    cy    = cell_of(word[49:34]);
    found = 0;
    r.id     = 16'd0;
    r.status = shg_pkg::ST_DONE;
    r.last   = 1'b1;
    case (cmd)
      shg_pkg::CMD_CLEAR: begin
        for (int i = 0; i < TABLE_SIZE; i++) fill_q[i] = 0;
        want_q.insert(want_q.size(), r);
      end
      shg_pkg::CMD_INSERT: begin
        b = bucket_of(cx, cy);
        if (fill_q[b] >= BUCKET_CAPACITY) begin
          r.status = shg_pkg::ST_FULL;
        end else begin
          ids_q[b][fill_q[b]] = pid;
          fill_q[b]++;
        end
        want_q.insert(want_q.size(), r);
      end
      shg_pkg::CMD_QUERY: begin
        // Cells left of or below zero wrap to the all-ones index.
        for (int dx = 0; dx < 3; dx++) begin
          for (int dy = 0; dy < 3; dy++) begin
            b = bucket_of(cx + 32'(dx) - 32'd1, cy + 32'(dy) - 32'd1);
            for (int e = 0; e < fill_q[b]; e++) begin
              r.id     = ids_q[b][e];
              r.status = shg_pkg::ST_ENTRY;
              r.last   = 1'b0;
              want_q.insert(want_q.size(), r);
              found++;
            end
          end
        end
        if (found == 0) begin
          r.id     = 16'd0;
          r.status = shg_pkg::ST_NONE;
          r.last   = 1'b1;
          want_q.insert(want_q.size(), r);
        end else begin
          want_q[want_q.size() - 1].last = 1'b1;
        end
      end
      default: begin
        want_q.insert(want_q.size(), r);
      end
    endcase
  endtask

  task automatic note_mismatch(string what, grid_result_t exp_r);
    if (mismatch_count_o < 10) begin
      $display("%t mismatch (%s): expected id=%h status=%0d last=%0d,",
               $realtime, what, exp_r.id, exp_r.status, exp_r.last);
      $display("    got id=%h status=%0d last=%0d",
               m_axis_tdata_i[15:0], m_axis_tdata_i[17:16], m_axis_tlast_i);
    end
    mismatch_count_o <= mismatch_count_o + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    grid_result_t exp_r;
    if (!rst_ni) begin
      cell_size_q      <= 16'd16;
      prime_x_q        <= 32'd73856093;
      prime_y_q        <= 32'd19349663;
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
      for (int i = 0; i < TABLE_SIZE; i++) fill_q[i] = 0;
      want_q.delete();
    end else begin
      // Register writes land in the shadow copy.
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          shg_pkg::REG_CELL_SIZE: cell_size_q <= pwdata_i[15:0];
          shg_pkg::REG_PRIME_X:   prime_x_q   <= pwdata_i;
          shg_pkg::REG_PRIME_Y:   prime_y_q   <= pwdata_i;
          default: ;
        endcase
      end
      // Compare an output transaction with the oldest expectation.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (want_q.size() == 0) begin
          exp_r.id = 16'd0; exp_r.status = shg_pkg::ST_ENTRY; exp_r.last = 1'b0;
          note_mismatch("unexpected result", exp_r);
        end else begin
          exp_r = want_q.pop_front();
          if (m_axis_tdata_i[15:0] !== exp_r.id || m_axis_tdata_i[17:16] !== exp_r.status ||
              m_axis_tlast_i !== exp_r.last)
            note_mismatch("field", exp_r);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) predict_grid(s_axis_tdata_i);
      pending_count_o <= want_q.size();
    end
  end

endmodule

[sim/tb_spatial_hash_grid_neighbours_core.sv]
// Testbench top that drives commands and registers of the spatial hash grid core.
`timescale 1ns / 1ps
module tb_spatial_hash_grid_neighbours_core;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [55:0] s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [23:0] m_data;
  logic        m_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          pending;
  int          burst_left = 0;
  logic [15:0] cur_cell = 16'd16;
  logic [15:0] hot_x [4];
  logic [15:0] hot_y [4];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  spatial_hash_grid_neighbours_core u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tdata_i(s_data),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_o(m_data),
    .m_axis_tlast_o(m_last),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  spatial_hash_grid_neighbours_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_i(s_ready), .s_axis_tdata_i(s_data),
    .m_axis_tvalid_i(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_i(m_data),
    .m_axis_tlast_i(m_last),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .mismatch_count_o(mismatches), .pending_count_o(pending)
  );

  // Offer one command in bursts with random gaps; returns after acceptance.
  task automatic send_cmd(logic [1:0] cmd, logic [15:0] pid, logic [15:0] x, logic [15:0] y);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    s_valid <= 1'b1;
    s_data  <= {6'd0, y, x, pid, cmd};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    burst_left--;
  endtask

  // Stop sending and let every expected result come out.
  task automatic drain;
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // A position near one of the hot spots, or anywhere now and then.
  function automatic logic [15:0] pick_pos(logic [15:0] hot);
    int span;
    span = (cur_cell == 16'd0) ? 1 : int'(cur_cell);
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'(int'(hot) + $urandom_range(0, (3 * span > 65535) ? 65535 : 3 * span));
  endfunction

  task automatic random_phase(int count);
    int          k;
    int          sel;
    logic [1:0]  cmd;
    for (int i = 0; i < 4; i++) begin
      hot_x[i] = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
      hot_y[i] = ($urandom_range(0, 3) == 0) ? 16'hFFF0 : 16'($urandom);
    end
    for (int n = 0; n < count; n++) begin
      k   = $urandom_range(0, 3);
      sel = $urandom_range(0, 99);
      if (sel < 48)      cmd = shg_pkg::CMD_INSERT;
      else if (sel < 94) cmd = shg_pkg::CMD_QUERY;
      else if (sel < 97) cmd = shg_pkg::CMD_CLEAR;
      else               cmd = shg_pkg::CMD_RESERVED;
      send_cmd(cmd, 16'($urandom), pick_pos(hot_x[k]), pick_pos(hot_y[k]));
    end
  endtask

  task automatic set_grid(logic [15:0] cs, logic [31:0] px, logic [31:0] py);
    drain();
    reg_write(shg_pkg::REG_CELL_SIZE, 32'(cs));
    reg_write(shg_pkg::REG_PRIME_X, px);
    reg_write(shg_pkg::REG_PRIME_Y, py);
    cur_cell = cs;
  endtask

  // Receiver: one long hold-off early on, then a mix of stall patterns.
  initial begin
    int run_len;
    int mode;
    @(posedge rst_ni);
    repeat (300) @(posedge clk_i);
    m_ready <= 1'b0;
    repeat (2500) @(posedge clk_i);
    forever begin
      run_len = $urandom_range(5, 80);
      mode    = $urandom_range(0, 3);
      repeat (run_len) begin
        case (mode)
          0: m_ready <= 1'b1;
          1: m_ready <= ($urandom_range(0, 1) == 1);
          2: m_ready <= ($urandom_range(0, 4) == 0);
          default: m_ready <= ($urandom_range(0, 4) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin
    #30ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings.
    send_cmd(shg_pkg::CMD_QUERY, 16'h1234, 16'd100, 16'd100);      // empty grid
    send_cmd(shg_pkg::CMD_INSERT, 16'h0000, 16'd0, 16'd0);
    send_cmd(shg_pkg::CMD_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 7; i++) begin
      send_cmd(shg_pkg::CMD_INSERT, 16'(16'hA000 + i), 16'd3, 16'd5);
    end
    send_cmd(shg_pkg::CMD_QUERY, 16'hFFFF, 16'd0, 16'd0);          // wraps below cell zero
    send_cmd(shg_pkg::CMD_QUERY, 16'd0, 16'hFFFF, 16'hFFFF);
    send_cmd(shg_pkg::CMD_QUERY, 16'd0, 16'd17, 16'd17);
    send_cmd(shg_pkg::CMD_RESERVED, 16'h5555, 16'hAAAA, 16'h5555);
    send_cmd(shg_pkg::CMD_CLEAR, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_cmd(shg_pkg::CMD_QUERY, 16'd0, 16'd0, 16'd0);
    send_cmd(shg_pkg::CMD_INSERT, 16'h00FF, 16'd0, 16'd0);
    send_cmd(shg_pkg::CMD_QUERY, 16'd0, 16'd15, 16'd15);

    // Everything in one bucket: full buckets and nine-fold duplicates.
    set_grid(16'd1, 32'd0, 32'd0);
    for (int i = 0; i < 8; i++) begin
      send_cmd(shg_pkg::CMD_INSERT, 16'(i), 16'($urandom), 16'($urandom));
    end
    send_cmd(shg_pkg::CMD_QUERY, 16'd0, 16'd40, 16'd40);
    random_phase(40);

    set_grid(16'd0, $urandom, $urandom);                  // zero cell size acts as one
    random_phase(55);
    set_grid(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(55);
    set_grid(16'($urandom_range(2, 40)), $urandom, $urandom);
    random_phase(60);
    set_grid(16'd3, 32'd1, 32'hFFFF_FFFF);
    random_phase(55);
    set_grid(16'($urandom_range(1, 300)), $urandom, $urandom);
    random_phase(60);

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/shg_pkg.sv
rtl/core/shg_front.sv
rtl/core/shg_fifo.sv
rtl/core/shg_back.sv
rtl/core/spatial_hash_grid_neighbours_core.sv
sim/spatial_hash_grid_neighbours_checker.sv
sim/tb_spatial_hash_grid_neighbours_core.sv
